### sv/simd_narrow_shift_absdiff_pairwise_macros.svh
// ----------------------------------------------------------------------------
// SIMD narrow/abs-diff/pairwise unit - assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk, reset i_rst_n.
// ----------------------------------------------------------------------------
`ifndef SIMD_NARROW_SHIFT_ABSDIFF_PAIRWISE_MACROS_SVH
`define SIMD_NARROW_SHIFT_ABSDIFF_PAIRWISE_MACROS_SVH

// same-cycle implication
`define SNSAP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define SNSAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/snsap_pkg.sv
// ----------------------------------------------------------------------------
// SIMD narrow/abs-diff/pairwise unit - package
// Payload types, operation codes and lane control struct.
// ----------------------------------------------------------------------------
package snsap_pkg;

    localparam logic [4:0] CMD_SHRN    = 5'd0;
    localparam logic [4:0] CMD_RSHRN   = 5'd1;
    localparam logic [4:0] CMD_SHRN2   = 5'd2;
    localparam logic [4:0] CMD_RSHRN2  = 5'd3;
    localparam logic [4:0] CMD_SABA    = 5'd4;
    localparam logic [4:0] CMD_UABA    = 5'd5;
    localparam logic [4:0] CMD_SABDL   = 5'd6;
    localparam logic [4:0] CMD_UABDL   = 5'd7;
    localparam logic [4:0] CMD_UABAL2  = 5'd13;
    localparam logic [4:0] CMD_SMAXP   = 5'd14;
    localparam logic [4:0] CMD_SMINP   = 5'd15;
    localparam logic [4:0] CMD_UMAXP   = 5'd16;
    localparam logic [4:0] CMD_UMINP   = 5'd17;

    typedef struct packed {
        logic [4:0]  cmd;
        logic [1:0]  lane_size;
        logic        full_width;
        logic [5:0]  shift_amount;
        logic [63:0] a_low;
        logic [63:0] a_high;
        logic [63:0] b_low;
        logic [63:0] b_high;
        logic [63:0] old_low;
        logic [63:0] old_high;
    } t_in;

    typedef struct packed {
        logic [63:0] res_low;
        logic [63:0] res_high;
    } t_out;

    typedef struct packed {
        logic [1:0] lsz;
        logic       sg;
        logic       minmax;
        logic       mx;
    } t_lane_ctl;

endpackage

### sv/snsap_lane.sv
// ----------------------------------------------------------------------------
// SIMD narrow/abs-diff/pairwise unit - 64-bit lane slice
// Per-element abs-diff accumulate or min/max at the selected element width.
// ----------------------------------------------------------------------------
module snsap_lane (
    input  snsap_pkg::t_lane_ctl i_ctl,
    input  logic [63:0]          i_x,
    input  logic [63:0]          i_y,
    input  logic [63:0]          i_o,
    output logic [63:0]          o_res
);
    import snsap_pkg::*;

    logic [63:0] res_sz [4];

    for (genvar g = 0; g < 4; g++) begin : g_sz
        localparam int W = 8 << g;
        localparam int N = 64 / W;
        always_comb begin
            logic [W-1:0] xe, ye, oe, df;
            logic         lt_xy, lt_yx;
            res_sz[g] = '0;
            for (int e = 0; e < N; e++) begin
                xe = i_x[e*W +: W];
                ye = i_y[e*W +: W];
                oe = i_o[e*W +: W];
                if (i_ctl.sg) begin
                    lt_xy = $signed(xe) < $signed(ye);
                    lt_yx = $signed(ye) < $signed(xe);
                end else begin
                    lt_xy = xe < ye;
                    lt_yx = ye < xe;
                end
                df = lt_xy ? (ye - xe) : (xe - ye);
                if (i_ctl.minmax) begin
                    if (i_ctl.mx) begin
                        res_sz[g][e*W +: W] = lt_yx ? xe : ye;
                    end else begin
                        res_sz[g][e*W +: W] = lt_xy ? xe : ye;
                    end
                end else begin
                    res_sz[g][e*W +: W] = oe + df;
                end
            end
        end
    end

    assign o_res = res_sz[i_ctl.lsz];

endmodule

### sv/snsap_narrow.sv
// ----------------------------------------------------------------------------
// SIMD narrow/abs-diff/pairwise unit - narrowing shifter
// Shifts each wide lane right, optionally rounding, and packs 64 bits.
// ----------------------------------------------------------------------------
module snsap_narrow (
    input  logic [127:0] i_a,
    input  logic [1:0]   i_lsz,
    input  logic [5:0]   i_sh,
    input  logic         i_rnd,
    output logic [63:0]  o_half
);
    import snsap_pkg::*;

    logic [63:0] half_sz [3];
    logic [5:0]  sh_m1;

    assign sh_m1 = i_sh - 6'd1;

    for (genvar g = 0; g < 3; g++) begin : g_sz
        localparam int NW = 8 << g;
        localparam int WW = 2 * NW;
        localparam int NL = 64 / NW;
        always_comb begin
            logic [WW-1:0] xe, sr, rb;
            half_sz[g] = '0;
            for (int i = 0; i < NL; i++) begin
                xe = i_a[i*WW +: WW];
                sr = xe >> i_sh;
                rb = xe >> sh_m1;
                half_sz[g][i*NW +: NW] = sr[NW-1:0]
                    + {{(NW-1){1'b0}}, (i_rnd && i_sh != 6'd0) ? rb[0] : 1'b0};
            end
        end
    end

    always_comb begin
        case (i_lsz)
            2'd0:    o_half = half_sz[0];
            2'd1:    o_half = half_sz[1];
            2'd2:    o_half = half_sz[2];
            default: o_half = '0;
        endcase
    end

endmodule

### sv/simd_narrow_shift_absdiff_pairwise.sv
// ----------------------------------------------------------------------------
// SIMD narrow/abs-diff/pairwise unit - top level
// Decodes the operation, routes operands into two 64-bit lanes and the
// narrowing shifter, merges the halves and registers the result.
//
//   channel  direction  handshake                   payload
//   in       input      i_in_valid / o_in_stall     i_in_data  (t_in)
//   out      output     o_out_valid / i_out_stall   o_out_data (t_out)
//
// One transfer per cycle unless stalled; results register in r_out or r_skid.
// Throughput is set by the single output register backed by a skid entry.
// Reset clears both valid flags; payload registers are not reset.
// o_in_stall is registered: high only while the skid entry is occupied.
// ----------------------------------------------------------------------------
`include "simd_narrow_shift_absdiff_pairwise_macros.svh"

module simd_narrow_shift_absdiff_pairwise (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  snsap_pkg::t_in     i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output snsap_pkg::t_out    o_out_data
);
    import snsap_pkg::*;

    function automatic logic [63:0] widen(input logic [31:0] s, input logic [1:0] lsz,
                                          input logic sg);
        logic [63:0] r;
        r = '0;
        case (lsz)
            2'd1: for (int k = 0; k < 4; k++)
                r[k*16 +: 16] = {{8{sg & s[k*8+7]}}, s[k*8 +: 8]};
            2'd2: for (int k = 0; k < 2; k++)
                r[k*32 +: 32] = {{16{sg & s[k*16+15]}}, s[k*16 +: 16]};
            2'd3: r = {{32{sg & s[31]}}, s};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [127:0] deint(input logic [127:0] s, input logic [1:0] lsz);
        logic [63:0] p, q;
        p = '0;
        q = '0;
        case (lsz)
            2'd0: for (int k = 0; k < 8; k++) begin
                p[k*8 +: 8] = s[(2*k)*8 +: 8];
                q[k*8 +: 8] = s[(2*k+1)*8 +: 8];
            end
            2'd1: for (int k = 0; k < 4; k++) begin
                p[k*16 +: 16] = s[(2*k)*16 +: 16];
                q[k*16 +: 16] = s[(2*k+1)*16 +: 16];
            end
            2'd2: for (int k = 0; k < 2; k++) begin
                p[k*32 +: 32] = s[(2*k)*32 +: 32];
                q[k*32 +: 32] = s[(2*k+1)*32 +: 32];
            end
            default: begin
                p = s[63:0];
                q = s[127:64];
            end
        endcase
        return {q, p};
    endfunction

    logic        is_nar, is_aba, is_wid, is_pw;
    logic [4:0]  wc;
    logic        wid_sg, wid_acc, wid_up;
    t_lane_ctl   ctl;
    logic [63:0] a_w [2];
    logic [63:0] b_w [2];
    logic [63:0] d_w [2];
    logic [63:0] lx [2];
    logic [63:0] ly [2];
    logic [63:0] lo [2];
    logic [63:0] lres [2];
    logic [127:0] pw_src [2];
    logic [127:0] pw_pq [2];
    logic [63:0] wa, wb, nar_h;
    t_out        n_res;

    t_out        r_out, r_skid;
    logic        r_out_valid, r_skid_valid;
    logic        in_take;

    assign a_w[0] = i_in_data.a_low;
    assign a_w[1] = i_in_data.a_high;
    assign b_w[0] = i_in_data.b_low;
    assign b_w[1] = i_in_data.b_high;
    assign d_w[0] = i_in_data.old_low;
    assign d_w[1] = i_in_data.old_high;

    assign is_nar = i_in_data.cmd <= CMD_RSHRN2;
    assign is_aba = i_in_data.cmd == CMD_SABA || i_in_data.cmd == CMD_UABA;
    assign is_wid = i_in_data.cmd >= CMD_SABDL && i_in_data.cmd <= CMD_UABAL2;
    assign is_pw  = i_in_data.cmd >= CMD_SMAXP && i_in_data.cmd <= CMD_UMINP;
    assign wc      = i_in_data.cmd - CMD_SABDL;
    assign wid_sg  = !wc[0];
    assign wid_acc = wc[1];
    assign wid_up  = wc >= 5'd4;
    assign wa = wid_up ? i_in_data.a_high : i_in_data.a_low;
    assign wb = wid_up ? i_in_data.b_high : i_in_data.b_low;

    always_comb begin
        ctl.lsz    = i_in_data.lane_size;
        ctl.minmax = is_pw;
        ctl.mx     = i_in_data.cmd == CMD_SMAXP || i_in_data.cmd == CMD_UMAXP;
        if (is_pw) begin
            ctl.sg = i_in_data.cmd <= CMD_SMINP;
        end else if (is_wid) begin
            ctl.sg = wid_sg;
        end else begin
            ctl.sg = i_in_data.cmd == CMD_SABA;
        end
    end

    assign pw_src[0] = i_in_data.full_width ? {i_in_data.a_high, i_in_data.a_low}
                                            : {i_in_data.b_low, i_in_data.a_low};
    assign pw_src[1] = {i_in_data.b_high, i_in_data.b_low};

    for (genvar j = 0; j < 2; j++) begin : g_lane
        assign pw_pq[j] = deint(pw_src[j], i_in_data.lane_size);
        always_comb begin
            if (is_pw) begin
                lx[j] = pw_pq[j][63:0];
                ly[j] = pw_pq[j][127:64];
                lo[j] = '0;
            end else if (is_wid) begin
                lx[j] = widen(wa[j*32 +: 32], i_in_data.lane_size, wid_sg);
                ly[j] = widen(wb[j*32 +: 32], i_in_data.lane_size, wid_sg);
                lo[j] = wid_acc ? d_w[j] : 64'd0;
            end else begin
                lx[j] = a_w[j];
                ly[j] = b_w[j];
                lo[j] = d_w[j];
            end
        end
        snsap_lane u_lane (
            .i_ctl (ctl),
            .i_x   (lx[j]),
            .i_y   (ly[j]),
            .i_o   (lo[j]),
            .o_res (lres[j])
        );
    end

    snsap_narrow u_narrow (
        .i_a    ({i_in_data.a_high, i_in_data.a_low}),
        .i_lsz  (i_in_data.lane_size),
        .i_sh   (i_in_data.shift_amount),
        .i_rnd  (i_in_data.cmd[0]),
        .o_half (nar_h)
    );

    // merge
    always_comb begin
        n_res = '0;
        if (is_nar) begin
            if (i_in_data.cmd[1]) begin
                n_res.res_low  = i_in_data.old_low;
                n_res.res_high = nar_h;
            end else begin
                n_res.res_low  = nar_h;
            end
        end else if (is_aba || is_pw) begin
            n_res.res_low  = lres[0];
            n_res.res_high = i_in_data.full_width ? lres[1] : 64'd0;
        end else if (is_wid && i_in_data.lane_size != 2'd0) begin
            n_res.res_low  = lres[0];
            n_res.res_high = lres[1];
        end
    end

    assign in_take = i_in_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_in_valid;
                if (i_in_valid) begin
                    r_out <= n_res;
                end
            end
        end else if (in_take) begin
            r_skid       <= n_res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `SNSAP_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_skid_valid, r_out_valid)
    `SNSAP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && i_out_stall,
        r_out_valid && $stable(r_out))
    `SNSAP_ASSERT_NEXT(a_take_lands, i_clk, i_rst_n, in_take && !(r_out_valid && i_out_stall),
        r_out_valid && !r_skid_valid)

endmodule

### verif/simd_narrow_shift_absdiff_pairwise_test.sv
// ----------------------------------------------------------------------------
// SIMD narrow/abs-diff/pairwise unit - testbench
// Drives directed and random vector operations through the valid/stall
// channels, predicts each result with a behavioural lane model and checks
// every output transfer in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module simd_narrow_shift_absdiff_pairwise_test;
    import snsap_pkg::*;

    localparam int N_RANDOM  = 600;
    localparam int MAX_CYCLE = 200000;

    class lane_scoreboard;
        t_out pending[$];
        int   n_errors;
        int   n_checked;

        function automatic logic [63:0] lmask(int w);
            return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        endfunction

        function automatic logic [63:0] lget(logic [127:0] v, int off, int w);
            return 64'((v >> off) & {64'd0, lmask(w)});
        endfunction

        function automatic logic less_than(logic [63:0] a, logic [63:0] b, int w, bit sg);
            logic [63:0] s;
            s = sg ? (64'd1 << ((w - 1) & 63)) : 64'd0;
            return (a ^ s) < (b ^ s);
        endfunction

        function automatic logic [63:0] absdiff(logic [63:0] a, logic [63:0] b, int w,
                                                bit sg);
            if (less_than(a, b, w, sg))
                return (b - a) & lmask(w);
            return (a - b) & lmask(w);
        endfunction

        function automatic t_out compute(t_in t);
            logic [127:0] a, b, d, r;
            logic [63:0]  x, y, v, h, p, q;
            int           w, n, sh, nl, total, base, c;
            bit           sg, acc, mx;
            a = {t.a_high, t.a_low};
            b = {t.b_high, t.b_low};
            d = {t.old_high, t.old_low};
            r = '0;
            w = 8 << t.lane_size;
            sh = int'(t.shift_amount);
            if (t.cmd <= CMD_RSHRN2) begin
                h = '0;
                if (t.lane_size <= 2) begin
                    n = w;
                    for (int i = 0; i < 64 / n; i++) begin
                        x = lget(a, i * 2 * n, 2 * n);
                        v = (sh >= 64) ? 64'd0 : (x >> sh);
                        if (t.cmd[0] && sh > 0)
                            v += (x >> (sh - 1)) & 64'd1;
                        h |= (v & lmask(n)) << (i * n);
                    end
                end
                if (t.cmd >= CMD_SHRN2)
                    r = {h, d[63:0]};
                else
                    r = {64'd0, h};
            end else if (t.cmd <= CMD_UABA) begin
                sg = (t.cmd == CMD_SABA);
                total = t.full_width ? 128 : 64;
                for (int i = 0; i < total / w; i++) begin
                    v = lget(d, i * w, w) + absdiff(lget(a, i * w, w), lget(b, i * w, w), w, sg);
                    r |= {64'd0, v & lmask(w)} << (i * w);
                end
            end else if (t.cmd <= CMD_UABAL2) begin
                c = int'(t.cmd) - int'(CMD_SABDL);
                sg = (c & 1) == 0;
                acc = (c & 2) != 0;
                base = (c >= 4) ? 64 : 0;
                if (t.lane_size != 0) begin
                    n = w / 2;
                    for (int i = 0; i < 128 / w; i++) begin
                        x = lget(a, base + i * n, n);
                        y = lget(b, base + i * n, n);
                        if (sg) begin
                            if (x[n - 1]) x |= ~lmask(n);
                            if (y[n - 1]) y |= ~lmask(n);
                            x &= lmask(w);
                            y &= lmask(w);
                        end
                        v = absdiff(x, y, w, sg);
                        if (acc)
                            v += lget(d, i * w, w);
                        r |= {64'd0, v & lmask(w)} << (i * w);
                    end
                end
            end else if (t.cmd <= CMD_UMINP) begin
                sg = (t.cmd <= CMD_SMINP);
                mx = (t.cmd == CMD_SMAXP || t.cmd == CMD_UMAXP);
                total = t.full_width ? 128 : 64;
                nl = total / w;
                for (int i = 0; i < nl; i++) begin
                    p = (2 * i < nl) ? lget(a, 2 * i * w, w) : lget(b, (2 * i - nl) * w, w);
                    q = (2 * i + 1 < nl) ? lget(a, (2 * i + 1) * w, w)
                                         : lget(b, (2 * i + 1 - nl) * w, w);
                    if (mx)
                        v = less_than(q, p, w, sg) ? p : q;
                    else
                        v = less_than(p, q, w, sg) ? p : q;
                    r |= {64'd0, v} << (i * w);
                end
            end
            return '{res_low: r[63:0], res_high: r[127:64]};
        endfunction

        function void note_input(t_in t);
            pending.push_back(compute(t));
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            n_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.res_low !== exp_r.res_low) begin
                $display("%0t: res_low expected %h actual %h", $time, exp_r.res_low,
                         got.res_low);
                n_errors++;
            end
            if (got.res_high !== exp_r.res_high) begin
                $display("%0t: res_high expected %h actual %h", $time, exp_r.res_high,
                         got.res_high);
                n_errors++;
            end
        endfunction
    endclass

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_in_valid = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;

    lane_scoreboard scb;
    int  cycle_count = 0;
    bit  quiet_phase = 1'b0;
    bit  hold_off = 1'b0;

    simd_narrow_shift_absdiff_pairwise dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLE) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            scb.note_input(i_in_data);
        if (i_rst_n && o_out_valid && !i_out_stall)
            scb.check_result(o_out_data);
    end

    // receiver: random stall bursts, one long hold-off, none at the end
    initial begin
        int k;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                for (k = 0; k < 60; k++) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_off = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                k = $urandom_range(1, 15);
                repeat (k) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            2: v = 64'h8080_8080_8080_8080;
            3: v = 64'h7f7f_7f7f_7f7f_7f7f;
            default: ;
        endcase
        return v;
    endfunction

    function automatic t_in rand_item();
        t_in t;
        t.cmd = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                              : 5'($urandom_range(0, 17));
        t.lane_size = 2'($urandom);
        t.full_width = 1'($urandom);
        t.shift_amount = ($urandom_range(0, 9) == 0) ? 6'($urandom)
                                                      : 6'($urandom_range(0, 32));
        t.a_low = rand64();
        t.a_high = rand64();
        t.b_low = rand64();
        t.b_high = rand64();
        t.old_low = rand64();
        t.old_high = rand64();
        return t;
    endfunction

    task automatic send(t_in t, bit gaps);
        int g;
        if (gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            g = $urandom_range(1, 15);
            repeat (g) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= t;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        t_in t;
        scb = new();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every code and size, edge shifts, extreme operands
        for (int c = 0; c < 18; c++) begin
            t = rand_item();
            t.cmd = 5'(c);
            t.lane_size = 2'(c % 4);
            t.full_width = 1'(c % 2);
            t.shift_amount = (c % 3 == 0) ? 6'd0 : ((c % 3 == 1) ? 6'd32 : 6'd1);
            t.a_low = (c % 2) ? '1 : 64'h8000_0000_0000_0000;
            t.b_high = (c % 2) ? '0 : 64'h7fff_ffff_ffff_ffff;
            send(t, 1'b0);
        end
        t = rand_item(); t.cmd = CMD_RSHRN; t.lane_size = 2'd3; send(t, 1'b0);
        t = rand_item(); t.cmd = 5'd31; send(t, 1'b0);
        t = rand_item(); t.cmd = CMD_UABDL; t.lane_size = 2'd0; send(t, 1'b0);
        t = rand_item(); t.cmd = CMD_SMAXP; t.lane_size = 2'd3; t.full_width = 1'b0;
        send(t, 1'b0);
        t = rand_item(); t.cmd = CMD_RSHRN2; t.shift_amount = 6'd63; t.lane_size = 2'd2;
        send(t, 1'b0);

        // long hold-off while the sender keeps offering
        hold_off = 1'b1;
        for (int i = 0; i < 20; i++) send(rand_item(), 1'b0);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 100) quiet_phase = 1'b1;
            send(rand_item(), !quiet_phase);
        end
        i_in_valid <= 1'b0;

        while (scb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d operations: all codes, lane sizes, widths and shifts,",
                 scb.n_checked);
        $display("including reserved sizes and undefined codes, under random stalls.");
        if (scb.n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
